### src/quantum_split_priority_queue_assert.svh
// assertion macros shared by the checker files
// each macro uses i_clk and i_rst_n from the scope where it is placed
`ifndef QUANTUM_SPLIT_PRIORITY_QUEUE_ASSERT_SVH
`define QUANTUM_SPLIT_PRIORITY_QUEUE_ASSERT_SVH

// same-cycle implication
`define QSPQ_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define QSPQ_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### src/qspq_pkg.sv
// ----------------------------------------------------------------------------
// qspq_pkg
// types and constants shared by the split priority queue
// ----------------------------------------------------------------------------
package qspq_pkg;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // command kinds
    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_POP  = 1'b1;

    // register map, word index
    localparam logic REG_TIME_QUANTUM = 1'b0;
    localparam logic [15:0] QUANTUM_RESET = 16'd4;

    typedef struct packed {
        logic [15:0] id;
        logic [15:0] slice;
        logic [7:0]  prio;
        logic        last;
    } t_entry;

    // what each cell hands to its right neighbor
    typedef struct packed {
        t_entry ent;
        logic   keep;
    } t_link;

    // broadcast operation to all cells
    typedef struct packed {
        logic   ins;
        logic   pop;
        t_entry ent;
    } t_cell_op;

endpackage

### src/qspq_if.sv
// ----------------------------------------------------------------------------
// qspq_if
// valid/ready channels for commands and results
// ----------------------------------------------------------------------------
interface qspq_in_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [15:0] exec_time;
    logic [7:0]  job_priority;

    modport source (output valid, kind, exec_time, job_priority, input ready);
    modport sink   (input valid, kind, exec_time, job_priority, output ready);
endinterface

interface qspq_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [15:0] out_job_id;
    logic [15:0] out_exec_time;
    logic [7:0]  out_priority;
    logic        ends_job;

    modport source (output valid, status, out_job_id, out_exec_time, out_priority,
                    ends_job, input ready);
    modport sink   (input valid, status, out_job_id, out_exec_time, out_priority,
                    ends_job, output ready);
endinterface

### src/qspq_cell.sv
// ----------------------------------------------------------------------------
// qspq_cell
// one slot of the sorted shift array
// ----------------------------------------------------------------------------
module qspq_cell (
    input  logic              i_clk,
    input  qspq_pkg::t_cell_op i_op,
    input  logic              i_occ,
    input  qspq_pkg::t_link   i_prev,
    input  qspq_pkg::t_entry  i_next,
    output qspq_pkg::t_link   o_link
);
    import qspq_pkg::*;

    t_entry r_ent;
    t_entry n_ent;
    logic   keep;

    // new word goes behind this entry
    assign keep = i_occ && ((r_ent.prio < i_op.ent.prio) ||
                  ((r_ent.prio == i_op.ent.prio) && (r_ent.slice >= i_op.ent.slice)));

    always_comb begin
        n_ent = r_ent;
        priority if (i_op.ins) begin
            if (keep) begin
                n_ent = r_ent;
            end else if (i_prev.keep) begin
                n_ent = i_op.ent;
            end else begin
                n_ent = i_prev.ent;
            end
        end else if (i_op.pop) begin
            n_ent = i_next;
        end else begin
            n_ent = r_ent;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ent <= n_ent;
    end

    assign o_link = '{ent: r_ent, keep: keep};

endmodule

### src/quantum_split_priority_queue.sv
// ----------------------------------------------------------------------------
// quantum_split_priority_queue
// sorted job queue with quantum splitting, built as a row of shift cells
// ----------------------------------------------------------------------------
//  channel   dir  handshake       word
//  i_cmd     in   valid/ready     kind, exec_time, job_priority
//  o_rsp     out  valid/ready     status, out_job_id, out_exec_time,
//                                 out_priority, ends_job
//  apb       in   psel/penable    time_quantum at byte address 0
//
//  a split push inserts its quantum slice, then its remainder in S_INS2,
//  since the cell row inserts one entry per cycle
//  the result is registered and shown the cycle after acceptance
//  a new command is taken while the previous result is being taken
//  synchronous active-low reset; no clearing pass, cell contents are unused
//  until the fill count covers them
// ----------------------------------------------------------------------------
module quantum_split_priority_queue #(
    parameter int QUEUE_DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    qspq_in_if.sink     i_cmd,
    qspq_out_if.source  o_rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import qspq_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    // one-hot sequencer
    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_INS2 = 2'b10
    } t_state;

    t_state        r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [15:0]   r_next_id, n_next_id;
    logic [15:0]   r_quantum;
    t_entry        r_pend, n_pend;

    // output register
    logic          r_out_valid, n_out_valid;
    logic [1:0]    r_status, n_status;
    t_entry        r_out, n_out;

    t_cell_op      w_op;
    t_link         w_link [QUEUE_DEPTH];
    logic          w_occ  [QUEUE_DEPTH];

    logic          acc;
    logic          split;
    logic [CW:0]   need_sum;
    logic          cfg_wr;

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_TIME_QUANTUM) ? {16'd0, r_quantum} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quantum <= QUANTUM_RESET;
        end else if (cfg_wr && (paddr[2] == REG_TIME_QUANTUM)) begin
            r_quantum <= pwdata[15:0];
        end
    end

    // ------------------------------------------------------------------
    // handshake and command decode
    // ------------------------------------------------------------------
    assign i_cmd.ready = (r_state == S_IDLE) && (!r_out_valid || o_rsp.ready);
    assign acc         = i_cmd.valid && i_cmd.ready;
    assign split       = i_cmd.exec_time > r_quantum;
    // room check: count plus one or two entries against depth
    assign need_sum    = {1'b0, r_count} + (split ? (CW+1)'(2) : (CW+1)'(1));

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_next_id   = r_next_id;
        n_pend      = r_pend;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_status    = r_status;
        n_out       = r_out;
        w_op        = '{ins: 1'b0, pop: 1'b0, ent: r_pend};

        unique case (r_state)
            S_IDLE: begin
                if (acc) begin
                    n_out_valid = 1'b1;
                    n_out       = '0;
                    if (i_cmd.kind == KIND_PUSH) begin
                        n_out.id = r_next_id;
                        if (need_sum > (CW+1)'(QUEUE_DEPTH)) begin
                            n_status = ST_FULL;
                        end else begin
                            n_status  = ST_OK;
                            n_next_id = r_next_id + 16'd1;
                            n_count   = r_count + CW'(1);
                            w_op.ins  = 1'b1;
                            if (split) begin
                                // quantum slice now, remainder next cycle
                                w_op.ent = '{id: r_next_id, slice: r_quantum,
                                             prio: i_cmd.job_priority, last: 1'b0};
                                n_pend   = '{id: r_next_id,
                                             slice: i_cmd.exec_time - r_quantum,
                                             prio: i_cmd.job_priority, last: 1'b1};
                                n_state  = S_INS2;
                            end else begin
                                w_op.ent = '{id: r_next_id, slice: i_cmd.exec_time,
                                             prio: i_cmd.job_priority, last: 1'b1};
                            end
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_status = ST_EMPTY;
                        end else begin
                            // head cell holds the best entry
                            n_status = ST_OK;
                            n_out    = w_link[0].ent;
                            n_count  = r_count - CW'(1);
                            w_op.pop = 1'b1;
                        end
                    end
                end
            end
            S_INS2: begin
                w_op.ins = 1'b1;
                w_op.ent = r_pend;
                n_count  = r_count + CW'(1);
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_next_id   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_next_id   <= n_next_id;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend   <= n_pend;
        r_status <= n_status;
        r_out    <= n_out;
    end

    // ------------------------------------------------------------------
    // cell row, head at index 0; inserts shift right, pops shift left
    // ------------------------------------------------------------------
    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        localparam logic [CW-1:0] IDX = CW'(g);
        t_link  prev;
        t_entry next;

        assign w_occ[g] = IDX < r_count;

        if (g == 0) begin : g_head
            // head always takes a new word it does not keep ahead of
            assign prev = '{ent: '0, keep: 1'b1};
        end else begin : g_body
            assign prev = w_link[g-1];
        end

        if (g == QUEUE_DEPTH - 1) begin : g_tail
            assign next = '0;
        end else begin : g_mid
            assign next = w_link[g+1].ent;
        end

        qspq_cell u_cell (
            .i_clk  (i_clk),
            .i_op   (w_op),
            .i_occ  (w_occ[g]),
            .i_prev (prev),
            .i_next (next),
            .o_link (w_link[g])
        );
    end

    // ------------------------------------------------------------------
    // result word
    // ------------------------------------------------------------------
    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.status        = r_status;
    assign o_rsp.out_job_id    = r_out.id;
    assign o_rsp.out_exec_time = r_out.slice;
    assign o_rsp.out_priority  = r_out.prio;
    assign o_rsp.ends_job      = r_out.last;

endmodule

### src/qspq_checker.sv
// ----------------------------------------------------------------------------
// qspq_checker
// port-level checks of the split priority queue
// ----------------------------------------------------------------------------
`include "quantum_split_priority_queue_assert.svh"

module qspq_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  i_status,
    input logic [15:0] i_job_id,
    input logic [15:0] i_exec_time,
    input logic [7:0]  i_priority,
    input logic        i_ends_job
);
    import qspq_pkg::*;

    // every accepted word yields a result next cycle
    `QSPQ_ASSERT_NEXT(a_result_follows, i_in_valid && i_in_ready, i_out_valid)

    // rejected push carries only the id
    `QSPQ_ASSERT_NOW(a_full_clean, i_out_valid && (i_status == ST_FULL),
        (i_exec_time == 16'd0) && (i_priority == 8'd0) && !i_ends_job)

    // empty pop carries nothing
    `QSPQ_ASSERT_NOW(a_empty_clean, i_out_valid && (i_status == ST_EMPTY),
        (i_job_id == 16'd0) && (i_exec_time == 16'd0) && (i_priority == 8'd0)
        && !i_ends_job)

    // stalled result holds
    `QSPQ_ASSERT_NEXT(a_hold, i_out_valid && !i_out_ready,
        i_out_valid && $stable(i_status) && $stable(i_job_id) && $stable(i_exec_time))

endmodule

bind quantum_split_priority_queue qspq_checker u_qspq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_cmd.valid),
    .i_in_ready  (i_cmd.ready),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_status    (o_rsp.status),
    .i_job_id    (o_rsp.out_job_id),
    .i_exec_time (o_rsp.out_exec_time),
    .i_priority  (o_rsp.out_priority),
    .i_ends_job  (o_rsp.ends_job)
);

### tb/tb_quantum_split_priority_queue.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_quantum_split_priority_queue
// self-checking bench for the quantum-splitting job queue: a mirror of the
// sorted entry list predicts every response word and checks it on arrival,
// while both channels stall at random and the quantum register is reprogrammed
// between phases
// ----------------------------------------------------------------------------
module tb_quantum_split_priority_queue;
    import qspq_pkg::*;

    localparam int DEPTH       = 64;
    localparam int HOLD_CYCLES = 300;   // long receiver hold-off
    localparam int STALL_LIMIT = 4000;  // watchdog: cycles with no traffic
    localparam int IDLE_PCT    = 19;
    localparam logic [2:0] QUANTUM_ADDR = {REG_TIME_QUANTUM, 2'b00};

    // one response word as seen on o_rsp
    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] job_id;
        logic [15:0] slice;
        logic [7:0]  prio;
        logic        ends;
    } t_rsp_word;

    // ------------------------------------------------------------------------
    // mirror of the job queue and the store of responses still to come
    // ------------------------------------------------------------------------
    class job_queue_mirror;
        t_entry      slots[$];      // kept in service order
        t_rsp_word   due_words[$];  // responses predicted, not yet seen
        logic [15:0] quantum;
        logic [15:0] next_id;
        int unsigned mismatches, checked;
        int unsigned pushes_ok, splits, rejects, pops_ok, empty_pops;

        function new();
            quantum = QUANTUM_RESET;
            next_id = '0;
        endfunction

        function int pending();
            return due_words.size();
        endfunction

        // goes behind everything that is served no later than it
        function void insert_entry(t_entry e);
            int pos = 0;
            while (pos < slots.size() && (slots[pos].prio < e.prio ||
                   (slots[pos].prio == e.prio && slots[pos].slice >= e.slice)))
                pos++;
            slots.insert(pos, e);
        endfunction

        function void take_command(logic kind, logic [15:0] et, logic [7:0] pr);
            t_rsp_word w;
            t_entry    head;
            logic      split;
            int        need;
            w = '0;
            w.status = ST_OK;
            if (kind == KIND_PUSH) begin
                split = et > quantum;
                need = split ? 2 : 1;
                w.job_id = next_id;
                if (slots.size() + need > DEPTH) begin
                    // rejected whole, id not consumed
                    w.status = ST_FULL;
                    rejects++;
                end else begin
                    if (split) begin
                        insert_entry('{id: next_id, slice: quantum, prio: pr, last: 1'b0});
                        insert_entry('{id: next_id, slice: et - quantum, prio: pr,
                                       last: 1'b1});
                        splits++;
                    end else begin
                        insert_entry('{id: next_id, slice: et, prio: pr, last: 1'b1});
                    end
                    next_id = next_id + 16'd1;
                    pushes_ok++;
                end
            end else if (slots.size() == 0) begin
                w.status = ST_EMPTY;
                empty_pops++;
            end else begin
                head = slots.pop_front();
                w.job_id = head.id;
                w.slice  = head.slice;
                w.prio   = head.prio;
                w.ends   = head.last;
                pops_ok++;
            end
            due_words.push_back(w);
        endfunction

        function void check_response(t_rsp_word got);
            t_rsp_word want;
            checked++;
            if (due_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: status %0d id %0d slice %0d prio %0d ends %0d",
                             got.status, got.job_id, got.slice, got.prio, got.ends);
                return;
            end
            want = due_words.pop_front();
            if (got.status != want.status || got.job_id != want.job_id ||
                got.slice != want.slice || got.prio != want.prio ||
                got.ends != want.ends) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch at %0t: expected status %0d id %0d slice %0d prio %0d ends %0d",
                             $realtime, want.status, want.job_id, want.slice, want.prio,
                             want.ends);
                    $display("                 got      status %0d id %0d slice %0d prio %0d ends %0d",
                             got.status, got.job_id, got.slice, got.prio, got.ends);
                end
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // clock, reset, channels and the block
    // ------------------------------------------------------------------------
    logic        i_clk;
    logic        i_rst_n;
    logic        psel, penable, pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    qspq_in_if  cmd();
    qspq_out_if rsp();

    quantum_split_priority_queue #(.QUEUE_DEPTH(DEPTH)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_rsp   (rsp),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    job_queue_mirror sb;
    bit          steady;        // no idling on either side while set
    bit          hold_request;  // asks the receiver for a long hold-off
    int unsigned words_taken;
    int unsigned stall_cycles;
    t_rsp_word   seen_word;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // monitor: command words feed the mirror, response words are checked
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cmd.valid && cmd.ready) begin
                sb.take_command(cmd.kind, cmd.exec_time, cmd.job_priority);
                words_taken++;
            end
            if (rsp.valid && rsp.ready) begin
                seen_word = '{status: rsp.status, job_id: rsp.out_job_id,
                              slice: rsp.out_exec_time, prio: rsp.out_priority,
                              ends: rsp.ends_job};
                sb.check_response(seen_word);
            end
        end
    end

    // watchdog: any handshake or register access counts as progress
    always @(posedge i_clk) begin
        if ((cmd.valid && cmd.ready) || (rsp.valid && rsp.ready) || psel) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("watchdog: no traffic for %0d cycles, %0d words outstanding",
                         STALL_LIMIT, sb.pending());
                $display("FAIL quantum_split_priority_queue");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // receiver: random back-pressure, plus one long hold-off on request
    // ------------------------------------------------------------------------
    initial begin
        rsp.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                rsp.ready <= 1'b0;
                // counted here so the sender keeps offering meanwhile
                repeat (HOLD_CYCLES - 1) begin
                    @(negedge i_clk);
                    rsp.ready <= 1'b0;
                end
            end else begin
                rsp.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // ------------------------------------------------------------------------
    // sender tasks
    // ------------------------------------------------------------------------
    // offers one command word, returns at the edge that takes it
    task automatic send_word(input logic kind, input logic [15:0] et,
                             input logic [7:0] pr);
        @(negedge i_clk);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            cmd.valid <= 1'b0;
            @(negedge i_clk);
        end
        cmd.valid        <= 1'b1;
        cmd.kind         <= kind;
        cmd.exec_time    <= et;
        cmd.job_priority <= pr;
        @(posedge i_clk);
        while (!cmd.ready) @(posedge i_clk);
    endtask

    // stop offering and let every predicted response come back
    task automatic wait_quiet();
        @(negedge i_clk);
        cmd.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // setup cycle, then access cycle; junk in the upper half must be dropped
    task automatic write_quantum(input logic [15:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= QUANTUM_ADDR;
        pwdata  <= {16'($urandom), value};
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        sb.quantum = value;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // random push or pop; push fields lean toward ties and the split boundary
    task automatic random_word(input int push_pct);
        logic [15:0] et;
        logic [7:0]  pr;
        int          near;
        int          pick;
        pick = $urandom_range(0, 99);
        if (pick < 25) begin
            near = int'(sb.quantum) + $urandom_range(0, 3) - 1;
            if (near < 0) near = 0;
            if (near > 65535) near = 65535;
            et = near[15:0];
        end else if (pick < 50) begin
            et = 16'($urandom_range(0, 15));
        end else if (pick < 60) begin
            et = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        end else begin
            et = 16'($urandom);
        end
        pick = $urandom_range(0, 99);
        if (pick < 50)
            pr = 8'($urandom_range(0, 3));
        else if (pick < 60)
            pr = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        else
            pr = 8'($urandom);
        if ($urandom_range(0, 99) < push_pct)
            send_word(KIND_PUSH, et, pr);
        else
            send_word(KIND_POP, 16'($urandom), 8'($urandom));
    endtask

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial begin
        logic [15:0] phase_quantum [7];
        cmd.valid        = 1'b0;
        cmd.kind         = KIND_PUSH;
        cmd.exec_time    = '0;
        cmd.job_priority = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        i_rst_n = 1'b0;
        steady  = 1'b0;
        hold_request = 1'b0;
        words_taken  = 0;
        stall_cycles = 0;
        sb = new();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed, reset quantum of 4: empty pop, split and unsplit jobs,
        // slice ties broken by insertion order, priority extremes
        send_word(KIND_POP,  16'h0000, 8'h00);
        send_word(KIND_PUSH, 16'd0,     8'd0);
        send_word(KIND_PUSH, 16'd4,     8'd0);
        send_word(KIND_PUSH, 16'd5,     8'd0);
        send_word(KIND_PUSH, 16'hFFFF,  8'hFF);
        send_word(KIND_PUSH, 16'd3,     8'd0);
        repeat (8) send_word(KIND_POP, 16'hFFFF, 8'hFF);

        // zero quantum: a zero job stays whole, anything else splits off a 0
        wait_quiet();
        write_quantum(16'd0);
        send_word(KIND_PUSH, 16'd0,    8'd7);
        send_word(KIND_PUSH, 16'd1,    8'd7);
        send_word(KIND_PUSH, 16'hFFFF, 8'd128);
        repeat (6) send_word(KIND_POP, 16'h0000, 8'h00);

        // widest quantum never splits
        wait_quiet();
        write_quantum(16'hFFFF);
        send_word(KIND_PUSH, 16'hFFFF, 8'd1);
        send_word(KIND_POP,  16'h0000, 8'h00);

        // random phases: fill toward full, then drain toward empty
        phase_quantum = '{16'd1, 16'd0, 16'hFFFF, 16'($urandom), 16'd16, 16'd300,
                          QUANTUM_RESET};
        for (int p = 0; p < 7; p++) begin
            wait_quiet();
            write_quantum(phase_quantum[p]);
            steady = (p == 5);
            for (int n = 0; n < 90; n++) begin
                // receiver stalls long while the sender keeps pushing
                if (p == 1 && n == 20) hold_request = 1'b1;
                random_word(n < 50 ? 88 : 20);
            end
        end
        steady = 1'b0;

        wait_quiet();
        repeat (6) @(posedge i_clk);

        $display("run covered %0d command words: %0d pushes stored (%0d split), %0d rejected full,",
                 words_taken, sb.pushes_ok, sb.splits, sb.rejects);
        $display("%0d pops served, %0d on empty; quantum 0, 1, 4, 16, 300, 65535 and random",
                 sb.pops_ok, sb.empty_pops);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("PASS quantum_split_priority_queue");
        end else begin
            $display("%0d mismatches, %0d words never arrived", sb.mismatches, sb.pending());
            $display("FAIL quantum_split_priority_queue");
        end
        $finish;
    end

endmodule
